/* hdl/lav_pkg.sv */
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared constants and the word types that pass between the block's parts.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC = 16;
  localparam int QB   = FRAC + 1;
  localparam int UW   = FRAC + 2;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [31:0] upward_x;
    logic signed [31:0] upward_y;
    logic signed [31:0] upward_z;
  } in_word_t;

  typedef struct packed {
    logic               which_matrix;
    logic [1:0]         row_index;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic               degenerate;
    logic               last_row;
  } out_word_t;

  typedef struct packed {
    logic signed [32:0] d_x;
    logic signed [32:0] d_y;
    logic signed [32:0] d_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } job_t;

endpackage

/* hdl/lav_front.sv */
// ----------------------------------------------------------------------------
// Look-at front end
// Accepts camera words, forms the view direction and holds jobs in a short queue.
// ----------------------------------------------------------------------------
module lav_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  lav_pkg::in_word_t in_word,
  output logic             job_valid,
  output lav_pkg::job_t    job,
  input  logic             job_take
);
  import lav_pkg::*;

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  job_t       nj;
  logic       do_push, do_pop;

  always_comb begin
    nj.d_x   = 33'(in_word.aim_x) - 33'(in_word.eye_x);
    nj.d_y   = 33'(in_word.aim_y) - 33'(in_word.eye_y);
    nj.d_z   = 33'(in_word.aim_z) - 33'(in_word.eye_z);
    nj.eye_x = in_word.eye_x;
    nj.eye_y = in_word.eye_y;
    nj.eye_z = in_word.eye_z;
    nj.up_x  = in_word.upward_x;
    nj.up_y  = in_word.upward_y;
    nj.up_z  = in_word.upward_z;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= nj;
    end
  end

endmodule

/* hdl/lav_outq.sv */
// ----------------------------------------------------------------------------
// Look-at result queue
// Two-entry queue that parts the row sequencer from the result receiver.
// ----------------------------------------------------------------------------
module lav_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               row_push,
  input  lav_pkg::out_word_t row_word,
  output logic               row_full,
  output logic               out_empty,
  input  logic               out_pop,
  output lav_pkg::out_word_t out_word
);
  import lav_pkg::*;

  out_word_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign row_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_word  = q_r[rp_r];
  assign do_push   = row_push && !row_full;
  assign do_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= row_word;
    end
  end

endmodule

/* hdl/lav_back.sv */
// ----------------------------------------------------------------------------
// Look-at back end
// Sequencer with a shared multiplier, square root and divider that builds the
// basis vectors and translations and then emits the six matrix rows.
// ----------------------------------------------------------------------------
module lav_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  lav_pkg::job_t      job,
  output logic               job_take,
  output logic               row_push,
  output lav_pkg::out_word_t row_word,
  input  logic               row_full
);
  import lav_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_ABS   = 8'b00000010,
    ST_SCALE = 8'b00000100,
    ST_MAC   = 8'b00001000,
    ST_SQRT  = 8'b00010000,
    ST_DSET  = 8'b00100000,
    ST_DIV   = 8'b01000000,
    ST_EMIT  = 8'b10000000
  } st_t;

  typedef enum logic [2:0] {
    MK_SQ = 3'd0,
    MK_CF = 3'd1,
    MK_CR = 3'd2,
    MK_DR = 3'd3,
    MK_DU = 3'd4,
    MK_DF = 3'd5
  } mk_t;

  function automatic logic [1:0] m3(input logic [2:0] x);
    logic [2:0] y;
    y = (x >= 3'd3) ? x - 3'd3 : x;
    return y[1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [32:0] ext_u(input logic signed [UW-1:0] v);
    return {{(33-UW){v[UW-1]}}, v};
  endfunction

  function automatic logic signed [31:0] ext32(input logic signed [UW-1:0] v);
    return {{(32-UW){v[UW-1]}}, v};
  endfunction

  st_t                 st_r;
  mk_t                 kind_r;
  logic signed [31:0]  eye_r [3];
  logic signed [31:0]  up_r  [3];
  logic signed [51:0]  vec_r [3];
  logic [51:0]         mag_r [3];
  logic                neg_r [3];
  logic signed [UW-1:0] f_r  [3];
  logic signed [UW-1:0] r_r  [3];
  logic signed [UW-1:0] cu_r [3];
  logic signed [31:0]  t_r   [3];
  logic                pass_r, degen_r;
  logic [1:0]          j_r, k_r;
  logic [5:0]          cnt_r;
  logic signed [65:0]  prod_r, acc_r;
  logic                pend_r, psub_r;
  logic [63:0]         n_r, res_r, bit_r;
  logic [31:0]         rem_r;
  logic [QB-1:0]       q_r, lo_r;
  logic [2:0]          e_r;

  logic [51:0]         mx;
  logic [1:0]          nterms, ip, iq, ik;
  logic signed [32:0]  opa, opb;
  logic                opsub;
  logic signed [65:0]  rs;
  logic [63:0]         rb;
  logic [32:0]         remx;
  logic [31:0]         len;
  logic [31+FRAC:0]    num;
  out_word_t           rw;

  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) begin
      mx = mag_r[1];
    end
    if (mag_r[2] > mx) begin
      mx = mag_r[2];
    end
  end

  always_comb begin
    ip     = m3({1'b0, j_r} + ((k_r == 2'd0) ? 3'd1 : 3'd2));
    iq     = m3({1'b0, j_r} + ((k_r == 2'd0) ? 3'd2 : 3'd1));
    ik     = m3({1'b0, k_r});
    opsub  = 1'b0;
    nterms = 2'd3;
    opa    = '0;
    opb    = '0;
    case (kind_r)
      MK_SQ: begin
        opa = {2'b00, mag_r[ik][30:0]};
        opb = {2'b00, mag_r[ik][30:0]};
      end
      MK_CF: begin
        nterms = 2'd2;
        opsub  = (k_r == 2'd1);
        opa    = ext_u(f_r[ip]);
        opb    = 33'(up_r[iq]);
      end
      MK_CR: begin
        nterms = 2'd2;
        opsub  = (k_r == 2'd1);
        opa    = ext_u(r_r[ip]);
        opb    = ext_u(f_r[iq]);
      end
      MK_DR: begin
        opa = ext_u(r_r[ik]);
        opb = 33'(eye_r[ik]);
      end
      MK_DU: begin
        opa = ext_u(cu_r[ik]);
        opb = 33'(eye_r[ik]);
      end
      MK_DF: begin
        opa = ext_u(f_r[ik]);
        opb = 33'(eye_r[ik]);
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign rs   = (acc_r + (66'sd1 <<< (FRAC - 1))) >>> FRAC;
  assign rb   = res_r + bit_r;
  assign len  = res_r[31:0];
  assign remx = {rem_r, lo_r[QB-1]};
  assign num  = ({mag_r[j_r][30:0], {FRAC{1'b0}}} + {{(FRAC + 1){1'b0}}, len[31:1]});

  assign job_take = (st_r == ST_IDLE) && job_valid;

  always_comb begin
    rw.which_matrix = (e_r >= 3'd3);
    rw.row_index    = (e_r >= 3'd3) ? 2'(e_r - 3'd3) : e_r[1:0];
    rw.degenerate   = degen_r;
    rw.last_row     = (e_r == 3'd5);
    rw.elem_0       = '0;
    rw.elem_1       = '0;
    rw.elem_2       = '0;
    rw.elem_3       = '0;
    if (!degen_r) begin
      case (e_r)
        3'd0: begin
          rw.elem_0 = ext32(r_r[0]);
          rw.elem_1 = ext32(r_r[1]);
          rw.elem_2 = ext32(r_r[2]);
          rw.elem_3 = t_r[0];
        end
        3'd1: begin
          rw.elem_0 = ext32(cu_r[0]);
          rw.elem_1 = ext32(cu_r[1]);
          rw.elem_2 = ext32(cu_r[2]);
          rw.elem_3 = t_r[1];
        end
        3'd2: begin
          rw.elem_0 = -ext32(f_r[0]);
          rw.elem_1 = -ext32(f_r[1]);
          rw.elem_2 = -ext32(f_r[2]);
          rw.elem_3 = t_r[2];
        end
        3'd3, 3'd4, 3'd5: begin
          rw.elem_0 = ext32(r_r[rw.row_index]);
          rw.elem_1 = ext32(cu_r[rw.row_index]);
          rw.elem_2 = -ext32(f_r[rw.row_index]);
          rw.elem_3 = eye_r[rw.row_index];
        end
        default: begin
          rw.elem_3 = '0;
        end
      endcase
    end
  end

  assign row_word = rw;
  assign row_push = (st_r == ST_EMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (job_valid) begin
            st_r <= ST_ABS;
          end
        end
        ST_ABS: begin
          if (vec_r[0] == '0 && vec_r[1] == '0 && vec_r[2] == '0) begin
            st_r <= ST_EMIT;
          end else begin
            st_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (mx < 52'(64'd1 << 31) && mx >= 52'(64'd1 << 30)) begin
            st_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (k_r == nterms && !pend_r) begin
            case (kind_r)
              MK_SQ: st_r <= ST_SQRT;
              MK_CF: if (j_r == 2'd2) st_r <= ST_ABS;
              MK_DF: st_r <= ST_EMIT;
              default: st_r <= ST_MAC;
            endcase
          end
        end
        ST_SQRT: begin
          if (cnt_r == 6'd31) begin
            st_r <= ST_DSET;
          end
        end
        ST_DSET: begin
          st_r <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_r == 6'(QB - 1)) begin
            st_r <= (j_r == 2'd2) ? ST_MAC : ST_DSET;
          end
        end
        ST_EMIT: begin
          if (!row_full && e_r == 3'd5) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        eye_r[0] <= job.eye_x;
        eye_r[1] <= job.eye_y;
        eye_r[2] <= job.eye_z;
        up_r[0]  <= job.up_x;
        up_r[1]  <= job.up_y;
        up_r[2]  <= job.up_z;
        vec_r[0] <= 52'(job.d_x);
        vec_r[1] <= 52'(job.d_y);
        vec_r[2] <= 52'(job.d_z);
        pass_r   <= 1'b0;
        degen_r  <= 1'b0;
        e_r      <= 3'd0;
      end
      ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= vec_r[i][51];
          mag_r[i] <= vec_r[i][51] ? 52'(-vec_r[i]) : 52'(vec_r[i]);
        end
        if (vec_r[0] == '0 && vec_r[1] == '0 && vec_r[2] == '0) begin
          degen_r <= 1'b1;
        end
      end
      ST_SCALE: begin
        if (mx >= 52'(64'd1 << 31)) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_r[i] >> 1;
          end
        end else if (mx < 52'(64'd1 << 30)) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end else begin
          kind_r <= MK_SQ;
          k_r    <= 2'd0;
          pend_r <= 1'b0;
          acc_r  <= '0;
        end
      end
      ST_MAC: begin
        if (k_r != nterms) begin
          prod_r <= opa * opb;
          psub_r <= opsub;
          pend_r <= 1'b1;
          k_r    <= k_r + 2'd1;
        end else begin
          pend_r <= 1'b0;
        end
        if (pend_r) begin
          acc_r <= psub_r ? acc_r - prod_r : acc_r + prod_r;
        end
        if (k_r == nterms && !pend_r) begin
          k_r   <= 2'd0;
          acc_r <= '0;
          case (kind_r)
            MK_SQ: begin
              n_r   <= acc_r[63:0];
              res_r <= '0;
              bit_r <= 64'd1 << 62;
              cnt_r <= '0;
            end
            MK_CF: begin
              vec_r[j_r] <= acc_r[51:0];
              j_r        <= (j_r == 2'd2) ? 2'd0 : j_r + 2'd1;
              if (j_r == 2'd2) begin
                pass_r <= 1'b1;
              end
            end
            MK_CR: begin
              cu_r[j_r] <= rs[UW-1:0];
              j_r       <= (j_r == 2'd2) ? 2'd0 : j_r + 2'd1;
              if (j_r == 2'd2) begin
                kind_r <= MK_DR;
              end
            end
            MK_DR: begin
              t_r[0] <= sat32(-rs);
              kind_r <= MK_DU;
            end
            MK_DU: begin
              t_r[1] <= sat32(-rs);
              kind_r <= MK_DF;
            end
            MK_DF: begin
              t_r[2] <= sat32(rs);
            end
            default: begin
              kind_r <= MK_SQ;
            end
          endcase
        end
      end
      ST_SQRT: begin
        if (n_r >= rb) begin
          n_r   <= n_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 6'd1;
        j_r   <= 2'd0;
      end
      ST_DSET: begin
        rem_r <= 32'(num >> QB);
        lo_r  <= num[QB-1:0];
        q_r   <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        if (remx >= {1'b0, len}) begin
          rem_r <= 32'(remx - {1'b0, len});
          q_r   <= {q_r[QB-2:0], 1'b1};
        end else begin
          rem_r <= remx[31:0];
          q_r   <= {q_r[QB-2:0], 1'b0};
        end
        lo_r  <= lo_r << 1;
        cnt_r <= cnt_r + 6'd1;
      end
      ST_EMIT: begin
        if (!row_full) begin
          e_r <= e_r + 3'd1;
        end
      end
      default: begin
        e_r <= 3'd0;
      end
    endcase
    if (st_r == ST_DIV && cnt_r == 6'(QB - 1)) begin
      if (pass_r) begin
        r_r[j_r] <= (remx >= {1'b0, len}) ?
                    (neg_r[j_r] ? -$signed({1'b0, q_r[QB-2:0], 1'b1})
                                : $signed({1'b0, q_r[QB-2:0], 1'b1})) :
                    (neg_r[j_r] ? -$signed({1'b0, q_r[QB-2:0], 1'b0})
                                : $signed({1'b0, q_r[QB-2:0], 1'b0}));
      end else begin
        f_r[j_r] <= (remx >= {1'b0, len}) ?
                    (neg_r[j_r] ? -$signed({1'b0, q_r[QB-2:0], 1'b1})
                                : $signed({1'b0, q_r[QB-2:0], 1'b1})) :
                    (neg_r[j_r] ? -$signed({1'b0, q_r[QB-2:0], 1'b0})
                                : $signed({1'b0, q_r[QB-2:0], 1'b0}));
      end
      if (j_r == 2'd2) begin
        j_r    <= 2'd0;
        k_r    <= 2'd0;
        pend_r <= 1'b0;
        acc_r  <= '0;
        kind_r <= pass_r ? MK_CR : MK_CF;
      end else begin
        j_r <= j_r + 2'd1;
      end
    end
  end

endmodule

/* hdl/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// Look-at view matrix generator
// Builds the right-handed world-to-camera and camera-to-world matrices from an
// eye position, a target point and an up hint, all in signed fixed point.
//
// Usage:
//   Camera words enter through a queue-style port: a word is taken on a clock
//   edge with in_push high and in_full low. The front end holds up to two
//   words, so a new word is taken while an earlier one is still being worked.
//   Each camera word yields six row words, world-to-camera rows 0 to 2 and then
//   camera-to-world rows 0 to 2, with last_row set on the sixth. A row word is
//   shown while out_empty is low and is taken on an edge with out_pop high.
//   The time a camera word spends in the back end is set by the shared
//   bit-serial square root, the restoring divider (one division per
//   component, six components) and the one-bit normalizing shifter, all
//   used twice per word. A word whose eye equals its target skips these and
//   goes straight to its degenerate rows.
//   When the receiver stalls, the two-entry result queue fills and the back
//   end waits; the front end keeps taking words until its own queue is full.
//   Synchronous reset empties both queues and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  lav_pkg::in_word_t  in_word,
  output logic               out_empty,
  input  logic               out_pop,
  output lav_pkg::out_word_t out_word
);
  import lav_pkg::*;

  job_t      job;
  logic      job_valid, job_take;
  out_word_t row_word;
  logic      row_push, row_full;

  lav_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  lav_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .row_push  (row_push),
    .row_word  (row_word),
    .row_full  (row_full)
  );

  lav_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_push  (row_push),
    .row_word  (row_word),
    .row_full  (row_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

/* tb/tb_look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Drives camera words through the queue-style input port and checks every row
// word against a fixed-point predictor of the look-at math. A directed table
// runs first, then random words, with random idling on both sides and one
// long receiver stall.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix;
  import lav_pkg::*;

  localparam logic W2C = 1'b0;
  localparam logic C2W = 1'b1;
  localparam int   ONE = 1 << FRAC;

  typedef longint vec3_t [3];
  typedef enum logic [1:0] {BY_MATH, EXP_DEGEN, EXP_IDENT} check_mode_t;
  typedef struct {
    in_word_t    w;
    check_mode_t mode;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_word_t  in_word = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_word_t out_word;

  out_word_t pending_rows[$];
  stim_row_t plan[$];
  int        mismatches = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;

  look_at_view_matrix u_top (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_word(in_word), .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit to_unit(input vec3_t v, output vec3_t u);
    longint unsigned mag[3];
    bit neg[3];
    longint unsigned m = 0, total = 0, len, q;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? longint'(-v[i]) : v[i];
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 31)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) total += mag[i] * mag[i];
    len = int_sqrt(total);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC) + (len >> 1)) / len;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic vec3_t cross_prod(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic longint rnd_fix(longint v);
    return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Queues the six row words that one camera word must produce.
  function automatic void predict_rows(in_word_t w, check_mode_t mode);
    vec3_t eye, aim, up, d, f, c, r, cu;
    longint m[6][4];
    bit ok;
    out_word_t o;
    eye = '{longint'(w.eye_x), longint'(w.eye_y), longint'(w.eye_z)};
    aim = '{longint'(w.aim_x), longint'(w.aim_y), longint'(w.aim_z)};
    up  = '{longint'(w.upward_x), longint'(w.upward_y), longint'(w.upward_z)};
    for (int i = 0; i < 3; i++) d[i] = aim[i] - eye[i];
    for (int k = 0; k < 6; k++) for (int i = 0; i < 4; i++) m[k][i] = 0;
    ok = to_unit(d, f);
    if (ok) begin
      c = cross_prod(f, up);
      ok = to_unit(c, r);
    end
    if (mode == EXP_IDENT) begin
      ok = 1'b1;
      for (int k = 0; k < 6; k++) m[k][k % 3] = ONE;
    end else if (mode == BY_MATH && ok) begin
      cu = cross_prod(r, f);
      for (int i = 0; i < 3; i++) cu[i] = rnd_fix(cu[i]);
      for (int i = 0; i < 3; i++) begin
        m[0][i] = r[i];
        m[1][i] = cu[i];
        m[2][i] = -f[i];
        m[3 + i][0] = r[i];
        m[3 + i][1] = cu[i];
        m[3 + i][2] = -f[i];
        m[3 + i][3] = eye[i];
      end
      m[0][3] = clip32(-rnd_fix(r[0] * eye[0] + r[1] * eye[1] + r[2] * eye[2]));
      m[1][3] = clip32(-rnd_fix(cu[0] * eye[0] + cu[1] * eye[1] + cu[2] * eye[2]));
      m[2][3] = clip32(rnd_fix(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]));
    end
    if (mode == EXP_DEGEN) ok = 1'b0;
    for (int k = 0; k < 6; k++) begin
      o.which_matrix = (k < 3) ? W2C : C2W;
      o.row_index    = 2'(k % 3);
      o.elem_0       = 32'(m[k][0]);
      o.elem_1       = 32'(m[k][1]);
      o.elem_2       = 32'(m[k][2]);
      o.elem_3       = 32'(m[k][3]);
      o.degenerate   = ~ok;
      o.last_row     = (k == 5);
      pending_rows.push_back(o);
    end
  endfunction

  function automatic in_word_t mk(int ex, int ey, int ez, int ax, int ay, int az,
                                  int ux, int uy, int uz);
    in_word_t w;
    w = '{ex, ey, ez, ax, ay, az, ux, uy, uz};
    return w;
  endfunction

  function automatic int near_val();
    return $urandom_range(0, 40 * ONE) - 20 * ONE;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int sel;
    sel = $urandom_range(0, 9);
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom};
    if (sel < 5) begin
      w = mk(near_val(), near_val(), near_val(), near_val(), near_val(), near_val(),
             near_val(), near_val(), near_val());
      if (sel == 0) {w.aim_x, w.aim_y, w.aim_z} = {w.eye_x, w.eye_y, w.eye_z};
      if (sel == 1) begin
        w.upward_x = w.aim_x - w.eye_x;
        w.upward_y = w.aim_y - w.eye_y;
        w.upward_z = w.aim_z - w.eye_z;
      end
    end
    return w;
  endfunction

  task automatic check_row(out_word_t got);
    out_word_t e;
    if (pending_rows.size() == 0) begin
      $display("%0t: unexpected row word %h", $time, got);
      mismatches++;
      return;
    end
    e = pending_rows.pop_front();
    if (got.which_matrix !== e.which_matrix || got.row_index !== e.row_index ||
        got.elem_0 !== e.elem_0 || got.elem_1 !== e.elem_1 ||
        got.elem_2 !== e.elem_2 || got.elem_3 !== e.elem_3 ||
        got.degenerate !== e.degenerate || got.last_row !== e.last_row) begin
      $display("%0t: mismatch expected m%0d r%0d %0d %0d %0d %0d dg%0b l%0b", $time,
               e.which_matrix, e.row_index, e.elem_0, e.elem_1, e.elem_2, e.elem_3,
               e.degenerate, e.last_row);
      $display("%0t:          actual   m%0d r%0d %0d %0d %0d %0d dg%0b l%0b", $time,
               got.which_matrix, got.row_index, got.elem_0, got.elem_1, got.elem_2,
               got.elem_3, got.degenerate, got.last_row);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_row(out_word);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n) break;
    end
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int n_dir;
    int mx;
    int mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    plan.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), EXP_DEGEN});
    plan.push_back('{mk(mx, mn, 5, mx, mn, 5, 0, ONE, 0), EXP_DEGEN});
    plan.push_back('{mk(0, 0, 0, 0, 0, -ONE, 0, 0, 0), EXP_DEGEN});
    plan.push_back('{mk(ONE, 0, 0, 3 * ONE, 0, 0, -ONE, 0, 0), EXP_DEGEN});
    plan.push_back('{mk(0, 0, 0, 0, 0, -ONE, 0, ONE, 0), EXP_IDENT});
    plan.push_back('{mk(mn, mn, mn, mx, mx, mx, 0, ONE, 0), BY_MATH});
    plan.push_back('{mk(mx, mx, mx, mn, mn, mn, ONE, 0, 0), BY_MATH});
    plan.push_back('{mk(mn, mn, mn, mx, mx, 0, mn, mx, mn), BY_MATH});
    plan.push_back('{mk(mx, mn, mx, mn, mx, mn, mx, mx, mx), BY_MATH});
    plan.push_back('{mk(0, 0, 0, 1, 0, 0, 0, 0, 1), BY_MATH});
    plan.push_back('{mk(0, 0, 0, 0, -1, 0, mn, 0, 0), BY_MATH});
    plan.push_back('{mk(mx, mx, mx, mx - 1, mx, mx, 0, 1, 0), BY_MATH});
    plan.push_back('{mk(mn, 0, mx, mn, ONE, mx, 0, 0, -1), BY_MATH});
    plan.push_back('{mk(-1, -1, -1, 0, 0, 0, -1, 0, 1), BY_MATH});
    plan.push_back('{mk(5 * ONE, 2 * ONE, -ONE, 0, ONE, 0, 0, ONE, 0), BY_MATH});
    plan.push_back('{mk(mx, mx, mx, 0, 0, 0, mx, mn, 0), BY_MATH});
    plan.push_back('{mk(ONE / 2, -ONE, 7, -ONE, ONE, ONE, 3, -5, 2), BY_MATH});
    plan.push_back('{mk(0, mx, 0, 0, mn, 0, ONE, ONE, 0), BY_MATH});
    n_dir = plan.size();
    for (int i = 0; i < 100; i++) plan.push_back('{random_word(), BY_MATH});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < plan.size(); i++) begin
      if (i == n_dir + 10) hold_req = 1'b1;
      if (i >= plan.size() - 20) calm = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_push <= 1'b1;
      in_word <= plan[i].w;
      @(posedge clk);
      while (in_full) @(posedge clk);
      predict_rows(plan[i].w, plan[i].mode);
    end
    in_push <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* look_at_view_matrix.f */
hdl/lav_pkg.sv
hdl/lav_front.sv
hdl/lav_outq.sv
hdl/lav_back.sv
hdl/look_at_view_matrix.sv
tb/tb_look_at_view_matrix.sv
